### hdl/rsc_pkg.sv
// Shared codes, types and template tables for the raster stream checker.
`default_nettype none

package rsc_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 16;
    localparam int CODE_W  = 3;
    localparam int POS_W   = 3;
    localparam int TID_W   = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // phase codes
    localparam logic [2:0] PH_INIT  = 3'd0;
    localparam logic [2:0] PH_TOP   = 3'd1;
    localparam logic [2:0] PH_DPI   = 3'd2;
    localparam logic [2:0] PH_SET0  = 3'd3;
    localparam logic [2:0] PH_SET1  = 3'd4;
    localparam logic [2:0] PH_SET2  = 3'd5;
    localparam logic [2:0] PH_RAS   = 3'd6;
    localparam logic [2:0] PH_DRAIN = 3'd7;

    // packet header steps
    localparam logic [2:0] HS_ESC = 3'd0;
    localparam logic [2:0] HS_T   = 3'd1;
    localparam logic [2:0] HS_LO  = 3'd2;
    localparam logic [2:0] HS_HI  = 3'd3;
    localparam logic [2:0] HS_PAY = 3'd4;

    // outcome codes
    localparam logic [2:0] OC_OK       = 3'd0;
    localparam logic [2:0] OC_HEADER   = 3'd1;
    localparam logic [2:0] OC_TRUNC    = 3'd2;
    localparam logic [2:0] OC_INIT     = 3'd3;
    localparam logic [2:0] OC_SETUP    = 3'd4;
    localparam logic [2:0] OC_RASTER   = 3'd5;
    localparam logic [2:0] OC_BAD_CHAR = 3'd6;

    // template ids
    localparam logic [2:0] TP_INIT = 3'd0;
    localparam logic [2:0] TP_DPI  = 3'd1;
    localparam logic [2:0] TP_S0   = 3'd2;
    localparam logic [2:0] TP_S1   = 3'd3;
    localparam logic [2:0] TP_S2   = 3'd4;
    localparam logic [2:0] TP_ROW  = 3'd5;
    localparam logic [2:0] TP_END  = 3'd6;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_BRACK  = 8'h5B;
    localparam logic [7:0] CH_NUM    = 8'h23;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [15:0] CNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   outcome;
        logic [CNT_W-1:0]    pages;
        logic [CNT_W-1:0]    dpi;
    } rsc_res_t;

    function automatic logic [POS_W-1:0] tmpl_len(input logic [TID_W-1:0] t);
        logic [POS_W-1:0] len;
        case (t)
            TP_INIT: len = 3'd2;
            TP_END:  len = 3'd4;
            TP_DPI, TP_S0, TP_S1, TP_S2, TP_ROW: len = 3'd5;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] tmpl_char(input logic [TID_W-1:0] t,
                                             input logic [POS_W-1:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (p)
            3'd0: c = CH_BRACK;
            3'd1: c = (t == TP_INIT) ? 8'h45 : 8'h2A;       // 'E' or '*'
            3'd2: begin
                case (t)
                    TP_DPI:  c = 8'h74;                     // 't'
                    TP_ROW:  c = 8'h62;                     // 'b'
                    TP_INIT: c = 8'h00;
                    default: c = 8'h72;                     // 'r'
                endcase
            end
            3'd3: begin
                case (t)
                    TP_DPI, TP_ROW: c = CH_NUM;
                    TP_S0, TP_S1:   c = CH_ZERO;
                    TP_S2:          c = 8'h31;              // '1'
                    TP_END:         c = 8'h43;              // 'C'
                    default:        c = 8'h00;
                endcase
            end
            3'd4: begin
                case (t)
                    TP_DPI:  c = 8'h52;                     // 'R'
                    TP_S0:   c = 8'h41;                     // 'A'
                    TP_S1:   c = 8'h46;                     // 'F'
                    TP_S2:   c = 8'h4E;                     // 'N'
                    TP_ROW:  c = 8'h57;                     // 'W'
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // template checked by the first matcher in each phase
    function automatic logic [TID_W-1:0] first_tmpl(input logic [2:0] ph);
        logic [TID_W-1:0] t;
        case (ph)
            PH_DPI:  t = TP_DPI;
            PH_SET0: t = TP_S0;
            PH_SET1: t = TP_S1;
            PH_SET2: t = TP_S2;
            PH_RAS:  t = TP_ROW;
            default: t = TP_INIT;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

### hdl/rsc_matcher.sv
// One prefix matcher: advances a template position by one payload byte.
`default_nettype none

module rsc_matcher (
    input  wire logic [rsc_pkg::TID_W-1:0] tmpl_id,
    input  wire logic                      active,
    input  wire logic                      alive_in,
    input  wire logic [rsc_pkg::POS_W-1:0] pos_in,
    input  wire logic [7:0]                byte_in,
    output      logic                      alive_out,
    output      logic [rsc_pkg::POS_W-1:0] pos_out,
    output      logic                      digit_hit
);
    import rsc_pkg::*;

    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pos_inc;
    logic [7:0]       ch_cur;
    logic [7:0]       ch_nxt;
    logic             is_digit;

    assign len      = tmpl_len(tmpl_id);
    assign pos_inc  = pos_in + 3'd1;
    assign ch_cur   = tmpl_char(tmpl_id, pos_in);
    assign ch_nxt   = tmpl_char(tmpl_id, pos_inc);
    assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);

    always_comb begin
        alive_out = alive_in;
        pos_out   = pos_in;
        digit_hit = 1'b0;
        if (active && alive_in && (pos_in < len)) begin
            if (ch_cur == CH_NUM) begin
                if (is_digit) begin
                    digit_hit = 1'b1;
                end else if (pos_inc >= len) begin
                    alive_out = 1'b0;
                end else if (ch_nxt == byte_in) begin
                    pos_out = pos_inc + 3'd1;
                end else begin
                    alive_out = 1'b0;
                    pos_out   = pos_inc;
                end
            end else if (ch_cur == byte_in) begin
                pos_out = pos_inc;
            end else begin
                alive_out = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/rsc_core.sv
// Checker state and per-word next-state logic for the raster stream checker.
`default_nettype none

module rsc_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic [7:0]        byte_in,
    input  wire logic              end_in,
    output      rsc_pkg::rsc_res_t res
);
    import rsc_pkg::*;

    logic [2:0]       phase_reg, phase_next;
    logic [2:0]       hs_reg, hs_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [POS_W-1:0] pos1_reg, pos1_next;
    logic [POS_W-1:0] pos2_reg, pos2_next;
    logic [1:0]       alive_reg, alive_next;
    logic [CNT_W-1:0] digit_reg, digit_next;
    logic [CNT_W-1:0] pages_reg, pages_next;
    logic [CNT_W-1:0] dpi_reg, dpi_next;

    logic [TID_W-1:0] t1;
    logic [7:0]       pay_byte;
    logic             m1_alive, m2_alive, m1_hit, m2_hit;
    logic [POS_W-1:0] m1_pos, m2_pos;
    logic [19:0]      digit_acc;
    logic [CNT_W-1:0] digit_upd;
    logic [CNT_W-1:0] left_dec;
    logic [CNT_W-1:0] len_full;
    logic             m1_done, m2_done;

    assign t1       = first_tmpl(phase_reg);
    assign pay_byte = (byte_in == CH_ESC) ? CH_BRACK : byte_in;

    rsc_matcher u_match_first (
        .tmpl_id   (t1),
        .active    (1'b1),
        .alive_in  (alive_reg[0]),
        .pos_in    (pos1_reg),
        .byte_in   (pay_byte),
        .alive_out (m1_alive),
        .pos_out   (m1_pos),
        .digit_hit (m1_hit)
    );

    rsc_matcher u_match_second (
        .tmpl_id   (TP_END),
        .active    (phase_reg == PH_RAS),
        .alive_in  (alive_reg[1]),
        .pos_in    (pos2_reg),
        .byte_in   (pay_byte),
        .alive_out (m2_alive),
        .pos_out   (m2_pos),
        .digit_hit (m2_hit)
    );

    // d*10 + digit, saturating
    assign digit_acc = {1'b0, digit_reg, 3'b000} + {3'b000, digit_reg, 1'b0}
                     + {16'd0, byte_in[3:0]};
    assign digit_upd = (digit_acc > {4'd0, CNT_MAX}) ? CNT_MAX : digit_acc[CNT_W-1:0];
    assign left_dec  = (left_reg == '0) ? '0 : left_reg - 16'd1;
    assign len_full  = {byte_in, len_lo_reg};
    assign m1_done   = m1_alive && (m1_pos == tmpl_len(t1));
    assign m2_done   = m2_alive && (m2_pos == tmpl_len(TP_END));

    always_comb begin
        phase_next  = phase_reg;
        hs_next     = hs_reg;
        len_lo_next = len_lo_reg;
        left_next   = left_reg;
        pos1_next   = pos1_reg;
        pos2_next   = pos2_reg;
        alive_next  = alive_reg;
        digit_next  = digit_reg;
        pages_next  = pages_reg;
        dpi_next    = dpi_reg;
        res.valid   = 1'b0;
        res.outcome = OC_OK;
        res.pages   = pages_reg;
        res.dpi     = dpi_reg;
        if (step_en) begin
            if (end_in) begin
                if (phase_reg != PH_DRAIN) begin
                    res.valid = 1'b1;
                    if (phase_reg == PH_TOP) begin
                        res.outcome = OC_OK;
                    end else if (hs_reg == HS_PAY) begin
                        res.outcome = OC_TRUNC;
                    end else begin
                        res.outcome = OC_HEADER;
                    end
                end
                // re-arm for the next stream
                phase_next  = PH_INIT;
                hs_next     = HS_ESC;
                len_lo_next = '0;
                left_next   = '0;
                pos1_next   = '0;
                pos2_next   = '0;
                alive_next  = 2'b11;
                digit_next  = '0;
                pages_next  = '0;
                dpi_next    = '0;
            end else if (phase_reg == PH_DRAIN) begin
                phase_next = PH_DRAIN;
            end else if (phase_reg == PH_TOP) begin
                if (byte_in == CH_FF) begin
                    if (pages_reg != CNT_MAX) begin
                        pages_next = pages_reg + 16'd1;
                    end
                end else if (byte_in == CH_ESC) begin
                    phase_next = PH_DPI;
                    hs_next    = HS_T;
                end else begin
                    res.valid   = 1'b1;
                    res.outcome = OC_BAD_CHAR;
                    phase_next  = PH_DRAIN;
                end
            end else begin
                unique case (hs_reg)
                    HS_ESC: begin
                        if (byte_in != CH_ESC) begin
                            res.valid   = 1'b1;
                            res.outcome = OC_HEADER;
                            phase_next  = PH_DRAIN;
                        end else begin
                            hs_next = HS_T;
                        end
                    end
                    HS_T: begin
                        if (byte_in != CH_T) begin
                            res.valid   = 1'b1;
                            res.outcome = OC_HEADER;
                            phase_next  = PH_DRAIN;
                        end else begin
                            hs_next = HS_LO;
                        end
                    end
                    HS_LO: begin
                        len_lo_next = byte_in;
                        hs_next     = HS_HI;
                    end
                    HS_HI: begin
                        left_next = len_full;
                        if (len_full == '0) begin
                            res.valid   = 1'b1;
                            res.outcome = OC_HEADER;
                            phase_next  = PH_DRAIN;
                        end else begin
                            hs_next    = HS_PAY;
                            pos1_next  = '0;
                            pos2_next  = '0;
                            alive_next = 2'b11;
                            digit_next = '0;
                        end
                    end
                    default: begin
                        // payload word
                        pos1_next  = m1_pos;
                        pos2_next  = m2_pos;
                        alive_next = {m2_alive, m1_alive};
                        // only the dpi and row templates carry a number field
                        if (m1_hit || m2_hit) begin
                            digit_next = digit_upd;
                        end
                        left_next = left_dec;
                        if (left_dec == '0) begin
                            hs_next = HS_ESC;
                            unique case (phase_reg) inside
                                PH_INIT: begin
                                    if (!m1_done) begin
                                        res.valid   = 1'b1;
                                        res.outcome = OC_INIT;
                                        phase_next  = PH_DRAIN;
                                    end else begin
                                        phase_next = PH_TOP;
                                    end
                                end
                                PH_DPI: begin
                                    if (!m1_done || digit_next == '0) begin
                                        res.valid   = 1'b1;
                                        res.outcome = OC_SETUP;
                                        phase_next  = PH_DRAIN;
                                    end else begin
                                        dpi_next   = digit_next;
                                        phase_next = PH_SET0;
                                    end
                                end
                                PH_SET0, PH_SET1, PH_SET2: begin
                                    if (!m1_done) begin
                                        res.valid   = 1'b1;
                                        res.outcome = OC_SETUP;
                                        phase_next  = PH_DRAIN;
                                    end else begin
                                        phase_next = phase_reg + 3'd1;
                                    end
                                end
                                PH_RAS: begin
                                    if (!(m1_done && digit_next != '0)) begin
                                        if (!m2_done) begin
                                            res.valid   = 1'b1;
                                            res.outcome = OC_RASTER;
                                            phase_next  = PH_DRAIN;
                                        end else begin
                                            phase_next = PH_TOP;
                                        end
                                    end
                                end
                                default: begin
                                    phase_next = phase_reg;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_INIT;
            hs_reg     <= HS_ESC;
            len_lo_reg <= '0;
            left_reg   <= '0;
            pos1_reg   <= '0;
            pos2_reg   <= '0;
            alive_reg  <= 2'b11;
            digit_reg  <= '0;
            pages_reg  <= '0;
            dpi_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            hs_reg     <= hs_next;
            len_lo_reg <= len_lo_next;
            left_reg   <= left_next;
            pos1_reg   <= pos1_next;
            pos2_reg   <= pos2_next;
            alive_reg  <= alive_next;
            digit_reg  <= digit_next;
            pages_reg  <= pages_next;
            dpi_reg    <= dpi_next;
        end
    end

endmodule

`default_nettype wire

### hdl/printer_raster_stream_checker_unit.sv
// Top level of the printer raster stream checker: input register, core, result register.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata = byte_value, s_tlast = is_end
//  m_      | out | m_tvalid/m_tready | m_tdata = outcome, page_count, dots_per_inch
//
// One word per cycle sustained while m_ does not stall; a word is judged from the input
// register and its result, if any, shows on m_ from the result register.
// The input register and result register decouple the two sides: a new word is
// taken while an earlier result waits, as long as the input register is empty
// or the result register can move.
// aresetn is synchronous, active low; it clears control state and all checker state.
// A stall on m_ holds the result and, once the input register is full, s_tready.
`default_nettype none

module printer_raster_stream_checker_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [rsc_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] byte_value
    input  wire logic                              s_tlast,  // is_end
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [2:0] outcome, [18:3] page_count, [34:19] dots_per_inch, [39:35] zero
    output      logic [rsc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import rsc_pkg::*;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_end_reg;
    logic             m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic             out_free;
    logic             step_en;
    rsc_res_t         res;

    assign out_free = !m_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    rsc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .byte_in (in_byte_reg),
        .end_in  (in_end_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                m_valid_reg <= step_en && res.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata[7:0];
            in_end_reg  <= s_tlast;
        end
        if (step_en && res.valid) begin
            m_data_reg <= {5'd0, res.dpi, res.pages, res.outcome};
        end
    end

endmodule

`default_nettype wire

### hdl/rsc_checker.sv
// Port-level checks for the raster stream checker, bound to the top level.
`default_nettype none

module rsc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rsc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rsc_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a result is never valid directly after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= OC_BAD_CHAR) && (m_tdata[39:35] == 5'd0))
        else $error("bad outcome code or padding");

    // a result needs an earlier input word or a stalled input side
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(!s_tready, 1)
                            || $past(s_tvalid, 2))
        else $error("result without an input word");

endmodule

bind printer_raster_stream_checker_unit rsc_checker u_rsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
